### src/hcrp_pkg.sv
// shared types and constants for the heating curve relay pwm block
// no dependencies; imported by hcrp_div, heating_curve_relay_pwm, hcrp_checker and the testbench
package hcrp_pkg;

  localparam int TEMP_W   = 16;            // temperature field width
  localparam int TIME_W   = 32;            // millisecond time width
  localparam int SEC_W    = 12;            // cycle period register width
  localparam int LOAD_W   = 7;             // load percent width
  localparam int PER_W    = SEC_W + 10;    // period in ms, seconds times 1000
  localparam int PROD_W   = PER_W + LOAD_W;
  localparam int DIFF_W   = TEMP_W + 1;    // positive temperature difference
  localparam int REM_W    = DIFF_W + LOAD_W;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = TEMP_W;

  localparam logic [LOAD_W-1:0] LOAD_FULL = LOAD_W'(100);
  localparam logic signed [TEMP_W-1:0] FLOOR_LIMIT_RST = TEMP_W'(10000);

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_CYCLE_PERIOD = 3'd0,
    REG_PEAK_OFF     = 3'd1,
    REG_PEAK_FULL    = 3'd2,
    REG_OFFPEAK_OFF  = 3'd3,
    REG_OFFPEAK_FULL = 3'd4,
    REG_FLOOR_LIMIT  = 3'd5,
    REG_PEAK_EN      = 3'd6,
    REG_OFFPEAK_EN   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] outdoor_temp;
    logic signed [TEMP_W-1:0] floor_temp;
    logic                     peak_tariff;
    logic [TIME_W-1:0]        now_ms;
  } in_t;

  typedef struct packed {
    logic              relay_on;
    logic [LOAD_W-1:0] load_percent;
    logic              relay_changed;
    logic              load_changed;
    logic              tariff_changed;
  } out_t;

endpackage

### src/hcrp_div.sv
// serial restoring divider: quotient of 100*num/den, one quotient bit per cycle
// depends on hcrp_pkg; caller guarantees num < den so the quotient is below 100
module hcrp_div import hcrp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIFF_W-1:0] num,
  input  logic [DIFF_W-1:0] den,
  output logic              done,
  output logic [LOAD_W-1:0] quot
);

  logic              busy;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  dsr;
  logic [2:0]        cnt;
  logic [REM_W-1:0]  num100;
  logic              fits;

  // 100 * num as a constant shift-add
  assign num100 = (REM_W'(num) << 6) + (REM_W'(num) << 5) + (REM_W'(num) << 2);
  assign fits   = rem >= dsr;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'(LOAD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 3'd1;
        if (cnt == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: one trial subtract per cycle, divisor shifts right
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num100;
      dsr  <= REM_W'(den) << (LOAD_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsr;
      end
      dsr  <= dsr >> 1;
      quot <= {quot[LOAD_W-2:0], fits};
    end
  end

endmodule

### src/heating_curve_relay_pwm.sv
// weather compensated time proportional heater relay, top level
// depends on hcrp_pkg and hcrp_div
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready     in_data  (in_t)
//   out       output     out_valid / out_ready   out_data (out_t)
//   cfg       input      cfg_we                  cfg_index, cfg_data
//
// a transaction steps through S_IDLE, S_PREP and S_FIN when the profile is
// inactive; when the load saturates, S_MUL runs the serial period times load
// multiply (7 load bits) before S_FIN; otherwise S_DIV first waits for the
// serial divider (7 quotient bits and its done strobe), then S_MUL follows.
// reset is synchronous and stops the cycle; the config registers go to
// their defaults. a new transaction is taken while a result waits in the
// output register; the sequencer holds in its last step until it drains.
module heating_curve_relay_pwm import hcrp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;

  // configuration registers
  logic [SEC_W-1:0]         cycle_period_s;
  logic signed [TEMP_W-1:0] peak_off_temp;
  logic signed [TEMP_W-1:0] peak_full_temp;
  logic signed [TEMP_W-1:0] offpeak_off_temp;
  logic signed [TEMP_W-1:0] offpeak_full_temp;
  logic signed [TEMP_W-1:0] floor_limit_temp;
  logic                     peak_enable;
  logic                     offpeak_enable;

  // controller state
  logic              cycle_running;
  logic [TIME_W-1:0] cycle_start_ms;
  logic [LOAD_W-1:0] held_load;
  logic              last_relay;
  logic              last_tariff;

  // per transaction working registers
  in_t               in_r;
  logic              active;
  logic              restart;
  logic [TIME_W-1:0] elapsed_r;
  logic [LOAD_W-1:0] load;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] mcand;
  logic [LOAD_W-1:0] mlp;
  logic [2:0]        cnt;

  // divider link
  logic              div_start;
  logic              div_done;
  logic [LOAD_W-1:0] div_quot;

  // profile selection and cycle timing
  logic signed [TEMP_W-1:0] sel_off;
  logic signed [TEMP_W-1:0] sel_full;
  logic                     sel_en;
  logic                     active_c;
  logic [PER_W-1:0]         period;
  logic [TIME_W-1:0]        elapsed;
  logic                     restart_c;
  logic signed [DIFF_W-1:0] num_s;
  logic signed [DIFF_W-1:0] den_s;
  logic                     at_off;
  logic                     at_full;
  logic [TIME_W+6:0]        e100;
  logic                     relay;
  logic                     temp_wr;
  logic signed [TEMP_W-1:0] temp_old;
  out_t                     out_next;
  out_t                     out_r_q;
  logic                     fin_fire;

  assign sel_off   = in_r.peak_tariff ? peak_off_temp : offpeak_off_temp;
  assign sel_full  = in_r.peak_tariff ? peak_full_temp : offpeak_full_temp;
  assign sel_en    = in_r.peak_tariff ? peak_enable : offpeak_enable;
  assign active_c  = sel_en && (in_r.floor_temp < floor_limit_temp);
  assign period    = (PER_W'(cycle_period_s) << 10) - (PER_W'(cycle_period_s) << 4)
                   - (PER_W'(cycle_period_s) << 3);
  assign elapsed   = in_r.now_ms - cycle_start_ms;
  assign restart_c = !cycle_running || (elapsed >= TIME_W'(period));
  assign at_off    = in_r.outdoor_temp >= sel_off;
  assign at_full   = in_r.outdoor_temp <= sel_full;
  assign num_s     = DIFF_W'(sel_off) - DIFF_W'(in_r.outdoor_temp);
  assign den_s     = DIFF_W'(sel_off) - DIFF_W'(sel_full);
  assign div_start = (state == S_PREP) && active_c && !at_off && !at_full;

  hcrp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (DIFF_W'(num_s)),
    .den   (DIFF_W'(den_s)),
    .done  (div_done),
    .quot  (div_quot)
  );

  // relay on while 100 * elapsed <= period * load, and period * load >= 100
  assign e100  = ((TIME_W + 7)'(elapsed_r) << 6) + ((TIME_W + 7)'(elapsed_r) << 5)
               + ((TIME_W + 7)'(elapsed_r) << 2);
  assign relay = active && (acc >= PROD_W'(100)) && (e100 <= (TIME_W + 7)'(acc));

  // result assembly
  always_comb begin
    out_next.relay_on       = relay;
    out_next.load_percent   = active ? load : held_load;
    out_next.relay_changed  = !cycle_running || (relay != last_relay);
    out_next.load_changed   = !cycle_running || (active && (load != held_load));
    out_next.tariff_changed = !cycle_running || (in_r.peak_tariff != last_tariff);
  end

  // temperature register writes stop the cycle only when the value changes
  always_comb begin
    case (cfg_index)
      REG_PEAK_OFF:     temp_old = peak_off_temp;
      REG_PEAK_FULL:    temp_old = peak_full_temp;
      REG_OFFPEAK_OFF:  temp_old = offpeak_off_temp;
      REG_OFFPEAK_FULL: temp_old = offpeak_full_temp;
      default:          temp_old = '0;
    endcase
  end
  assign temp_wr = cfg_we && (cfg_index == REG_PEAK_OFF || cfg_index == REG_PEAK_FULL ||
                   cfg_index == REG_OFFPEAK_OFF || cfg_index == REG_OFFPEAK_FULL) &&
                   (cfg_data != temp_old);

  assign in_ready = (state == S_IDLE);
  assign out_data = out_r_q;
  assign fin_fire = (state == S_FIN) && (!out_valid || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_period_s    <= '0;
      peak_off_temp     <= '0;
      peak_full_temp    <= '0;
      offpeak_off_temp  <= '0;
      offpeak_full_temp <= '0;
      floor_limit_temp  <= FLOOR_LIMIT_RST;
      peak_enable       <= 1'b1;
      offpeak_enable    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CYCLE_PERIOD: cycle_period_s    <= cfg_data[SEC_W-1:0];
        REG_PEAK_OFF:     peak_off_temp     <= cfg_data;
        REG_PEAK_FULL:    peak_full_temp    <= cfg_data;
        REG_OFFPEAK_OFF:  offpeak_off_temp  <= cfg_data;
        REG_OFFPEAK_FULL: offpeak_full_temp <= cfg_data;
        REG_FLOOR_LIMIT:  floor_limit_temp  <= cfg_data;
        REG_PEAK_EN:      peak_enable       <= cfg_data[0];
        REG_OFFPEAK_EN:   offpeak_enable    <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // sequencer and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      cycle_running  <= 1'b0;
      cycle_start_ms <= '0;
      held_load      <= '0;
      last_relay     <= 1'b0;
      last_tariff    <= 1'b0;
    end else begin
      // output valid: set when a result loads, cleared when it is taken
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // a changed temperature setting stops the cycle, an active restart runs it
      if (temp_wr) begin
        cycle_running <= 1'b0;
      end else if (fin_fire && active && restart) begin
        cycle_running <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (!active_c) begin
            state <= S_FIN;
          end else if (at_off || at_full) begin
            state <= S_MUL;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt == 3'd0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            last_relay  <= relay;
            last_tariff <= in_r.peak_tariff;
            if (active) begin
              held_load <= load;
              if (restart) begin
                cycle_start_ms <= in_r.now_ms;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          in_r <= in_data;
        end
      end
      S_PREP: begin
        active    <= active_c;
        restart   <= restart_c;
        elapsed_r <= restart_c ? '0 : elapsed;
        load      <= at_off ? '0 : LOAD_FULL;
        acc       <= '0;
        mcand     <= PROD_W'(period);
        mlp       <= at_off ? '0 : LOAD_FULL;
        cnt       <= 3'(LOAD_W - 1);
      end
      S_DIV: begin
        if (div_done) begin
          load <= div_quot;
          mlp  <= div_quot;
        end
      end
      S_MUL: begin
        // one load bit per cycle, multiplicand shifts left
        if (mlp[0]) begin
          acc <= acc + mcand;
        end
        mcand <= mcand << 1;
        mlp   <= mlp >> 1;
        cnt   <= cnt - 3'd1;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          out_r_q <= out_next;
        end
      end
      default: ;
    endcase
  end

endmodule

### dv/hcrp_checker.sv
// transaction checker for heating_curve_relay_pwm: predicts every result and compares it
// depends on hcrp_pkg; instantiated beside the block by tb_heating_curve_relay_pwm
module hcrp_checker import hcrp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_t              in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_t             out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending_results
);

  localparam int MAX_PRINTED = 200;

  // register copies
  logic [SEC_W-1:0]         period_s;
  logic signed [TEMP_W-1:0] pk_off, pk_full, op_off, op_full, floor_lim;
  logic                     pk_en, op_en;

  // controller state copies
  logic              running;
  logic [TIME_W-1:0] start_ms;
  logic [LOAD_W-1:0] load_q;
  logic              relay_q, tariff_q;

  out_t predicted_relay_q[$];
  int   mismatches = 0;
  int   results_seen = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  // heating curve: zero at or above off, full at or below full, linear between
  function automatic logic [LOAD_W-1:0] curve_load(input int ext, input int off,
                                                   input int full);
    if (ext >= off) return '0;
    if (ext <= full) return LOAD_FULL;
    return LOAD_W'((100 * (off - ext)) / (off - full));
  endfunction

  // a changed temperature setting stops the running cycle
  task automatic apply_config(input reg_idx_t idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_CYCLE_PERIOD: period_s = data[SEC_W-1:0];
      REG_PEAK_OFF: begin
        if (data != pk_off) begin
          pk_off = data;
          running = 1'b0;
        end
      end
      REG_PEAK_FULL: begin
        if (data != pk_full) begin
          pk_full = data;
          running = 1'b0;
        end
      end
      REG_OFFPEAK_OFF: begin
        if (data != op_off) begin
          op_off = data;
          running = 1'b0;
        end
      end
      REG_OFFPEAK_FULL: begin
        if (data != op_full) begin
          op_full = data;
          running = 1'b0;
        end
      end
      REG_FLOOR_LIMIT: floor_lim = data;
      REG_PEAK_EN:     pk_en = data[0];
      REG_OFFPEAK_EN:  op_en = data[0];
      default: ;
    endcase
  endtask

  // one input transaction gives exactly one result
  task automatic step_heating_curve(input in_t item);
    out_t              res;
    logic              en, relay, refresh;
    int                off, full, ext, flr, lim;
    longint unsigned   per_ms, on_ms;
    logic [TIME_W-1:0] elapsed;
    logic [LOAD_W-1:0] prev_load;
    refresh   = !running;
    prev_load = load_q;
    relay     = 1'b0;
    ext       = item.outdoor_temp;
    flr       = item.floor_temp;
    lim       = floor_lim;
    if (item.peak_tariff) begin
      en   = pk_en;
      off  = pk_off;
      full = pk_full;
    end else begin
      en   = op_en;
      off  = op_off;
      full = op_full;
    end
    // heating active: update load and advance the relay cycle
    if (en && flr < lim) begin
      per_ms  = longint'(period_s) * 1000;
      load_q  = curve_load(ext, off, full);
      elapsed = item.now_ms - start_ms;
      if (!running || elapsed >= per_ms) begin
        start_ms = item.now_ms;
        running  = 1'b1;
      end
      elapsed = item.now_ms - start_ms;
      on_ms   = (per_ms * load_q) / 100;
      if (on_ms != 0 && elapsed <= on_ms) relay = 1'b1;
    end
    res.relay_on       = relay;
    res.load_percent   = load_q;
    res.relay_changed  = refresh || (relay != relay_q);
    res.load_changed   = refresh || (prev_load != load_q);
    res.tariff_changed = refresh || (item.peak_tariff != tariff_q);
    relay_q  = relay;
    tariff_q = item.peak_tariff;
    predicted_relay_q.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic compare_result(input out_t got);
    out_t want;
    results_seen++;
    if (predicted_relay_q.size() == 0) begin
      report_mismatch("result with no prediction waiting");
      return;
    end
    want = predicted_relay_q.pop_front();
    check_field("relay_on", 8'(got.relay_on), 8'(want.relay_on));
    check_field("load_percent", 8'(got.load_percent), 8'(want.load_percent));
    check_field("relay_changed", 8'(got.relay_changed), 8'(want.relay_changed));
    check_field("load_changed", 8'(got.load_changed), 8'(want.load_changed));
    check_field("tariff_changed", 8'(got.tariff_changed), 8'(want.tariff_changed));
  endtask

  // sample all channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      period_s  = '0;
      pk_off    = '0;
      pk_full   = '0;
      op_off    = '0;
      op_full   = '0;
      floor_lim = FLOOR_LIMIT_RST;
      pk_en     = 1'b1;
      op_en     = 1'b1;
      running   = 1'b0;
      start_ms  = '0;
      load_q    = '0;
      relay_q   = 1'b0;
      tariff_q  = 1'b0;
      predicted_relay_q.delete();
    end else begin
      if (cfg_we) apply_config(reg_idx_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) step_heating_curve(in_data);
      if (out_valid && out_ready) compare_result(out_data);
    end
    pending_results <= predicted_relay_q.size();
    fail_count      <= mismatches;
  end

endmodule

### dv/tb_heating_curve_relay_pwm.sv
// testbench top for heating_curve_relay_pwm: clock, reset, stimulus and verdict
// depends on hcrp_pkg, heating_curve_relay_pwm and hcrp_checker
module tb_heating_curve_relay_pwm;
  import hcrp_pkg::*;

  localparam int NUM_REGS     = 8;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  in_t              in_data;
  logic             out_valid;
  logic             out_ready;
  out_t             out_data;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               fail_count;
  int               pending_results;

  heating_curve_relay_pwm dut (.*);
  hcrp_checker checker_i (.*);

  // register values for the current phase, by register index
  int                reg_val[NUM_REGS];
  logic              no_gap = 1'b0;
  logic              cur_tariff = 1'b1;
  logic [TIME_W-1:0] cur_now = '0;
  int                cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("heating_curve_relay_pwm regression: fail");
    $finish;
  end

  // result side stalls: ready stretches with random stalls between
  initial begin
    int hold, stall, r;
    forever begin
      r = $urandom_range(0, 99);
      hold  = (r < 20) ? $urandom_range(30, 120) : $urandom_range(1, 8);
      r = $urandom_range(0, 99);
      stall = (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(10, 60);
      out_ready <= 1'b1;
      repeat (hold) @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  function automatic logic [TEMP_W-1:0] t16(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[TEMP_W-1:0];
  endfunction

  function automatic in_t mk_item(input int ext, input int flr, input logic tariff,
                                  input logic [TIME_W-1:0] now);
    in_t item;
    item.outdoor_temp = t16(ext);
    item.floor_temp   = t16(flr);
    item.peak_tariff  = tariff;
    item.now_ms       = now;
    return item;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gap || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // drive one input transaction and wait for its acceptance
  task automatic send_item(input in_t item, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // write all registers back to back; unused upper data bits carry noise
  task automatic set_config();
    logic [CFG_W-1:0] data;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (reg_idx_t'(i))
        REG_CYCLE_PERIOD: data = {(CFG_W-SEC_W)'($urandom), SEC_W'(reg_val[i])};
        REG_PEAK_EN, REG_OFFPEAK_EN: data = {(CFG_W-1)'($urandom), reg_val[i][0]};
        default: data = t16(reg_val[i]);
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data  <= data;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic pick_profile(output int off, output int full);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      full = int'($urandom_range(0, 6000)) - 3000;
      off  = full + int'($urandom_range(1, 4000));
    end else if (r == 6) begin
      off  = 32767;
      full = -32768;
    end else if (r == 7) begin
      off  = $signed(16'($urandom));
      full = $signed(16'($urandom));
    end else if (r == 8) begin
      off  = int'($urandom_range(0, 6000)) - 3000;
      full = off;
    end else begin
      full = int'($urandom_range(0, 6000)) - 3000;
      off  = full - int'($urandom_range(1, 2000));
    end
  endtask

  // new phase settings; each register keeps its old value half of the time
  task automatic pick_config();
    int cand[NUM_REGS];
    int r;
    r = $urandom_range(0, 9);
    cand[REG_CYCLE_PERIOD] = (r == 0) ? 0 : (r == 1) ? 3600 :
                             (r == 2) ? $urandom_range(0, 3600) : $urandom_range(1, 20);
    pick_profile(cand[REG_PEAK_OFF], cand[REG_PEAK_FULL]);
    pick_profile(cand[REG_OFFPEAK_OFF], cand[REG_OFFPEAK_FULL]);
    r = $urandom_range(0, 9);
    cand[REG_FLOOR_LIMIT] = (r == 0) ? 32767 : (r == 1) ? -32768 :
                            (r == 2) ? int'($signed(16'($urandom))) :
                            $urandom_range(1000, 5000);
    cand[REG_PEAK_EN]    = ($urandom_range(0, 4) != 0);
    cand[REG_OFFPEAK_EN] = ($urandom_range(0, 4) != 0);
    for (int i = 0; i < NUM_REGS; i++)
      if ($urandom_range(0, 1)) reg_val[i] = cand[i];
  endtask

  // mostly temperatures around the active curve and time moving forward
  task automatic random_item(output in_t item);
    int r, off, full, lo, hi, ext, flr, lim;
    longint unsigned per_ms;
    if ($urandom_range(0, 3) == 0) cur_tariff = ~cur_tariff;
    off  = cur_tariff ? reg_val[REG_PEAK_OFF] : reg_val[REG_OFFPEAK_OFF];
    full = cur_tariff ? reg_val[REG_PEAK_FULL] : reg_val[REG_OFFPEAK_FULL];
    lo   = ((off < full) ? off : full) - 200;
    hi   = ((off < full) ? full : off) + 200;
    r    = $urandom_range(0, 9);
    ext  = (r < 7) ? lo + int'($urandom_range(0, hi - lo)) : $signed(16'($urandom));
    lim  = reg_val[REG_FLOOR_LIMIT];
    r    = $urandom_range(0, 9);
    flr  = (r < 8) ? lim - 1 - int'($urandom_range(0, 2000)) :
           (r == 8) ? lim : $signed(16'($urandom));
    per_ms = longint'(reg_val[REG_CYCLE_PERIOD]) * 1000;
    r = $urandom_range(0, 9);
    if (r < 8) cur_now = cur_now + TIME_W'($urandom_range(0, int'(per_ms * 3 / 2) + 10));
    else if (r == 8) cur_now = $urandom;
    else cur_now = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 3000));
    item = mk_item(ext, flr, cur_tariff, cur_now);
  endtask

  initial begin
    logic [TIME_W-1:0] base;
    in_t item;
    int  sent, phase_len;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: 10 s cycle, distinct peak and off-peak curves
    reg_val[REG_CYCLE_PERIOD] = 10;
    reg_val[REG_PEAK_OFF]     = 2000;
    reg_val[REG_PEAK_FULL]    = -1000;
    reg_val[REG_OFFPEAK_OFF]  = 1500;
    reg_val[REG_OFFPEAK_FULL] = -500;
    reg_val[REG_FLOOR_LIMIT]  = 2500;
    reg_val[REG_PEAK_EN]      = 1;
    reg_val[REG_OFFPEAK_EN]   = 1;
    set_config();
    // half load, cycle starting just before the time wrap
    base = 32'hFFFF_F000;
    send_item(mk_item(500, 0, 1'b1, base), gap_len());
    send_item(mk_item(500, 0, 1'b1, base + 32'd5000), gap_len());
    send_item(mk_item(500, 0, 1'b1, base + 32'd5001), gap_len());
    send_item(mk_item(500, 0, 1'b1, base + 32'd9999), gap_len());
    send_item(mk_item(500, 0, 1'b1, base + 32'd10000), gap_len());
    // curve edges and temperature extremes
    send_item(mk_item(2000, 0, 1'b1, base + 32'd11000), gap_len());
    send_item(mk_item(2001, 0, 1'b1, base + 32'd11001), gap_len());
    send_item(mk_item(-1000, 0, 1'b1, base + 32'd11002), gap_len());
    send_item(mk_item(-32768, -32768, 1'b1, base + 32'd11003), gap_len());
    send_item(mk_item(32767, 0, 1'b1, base + 32'd11004), gap_len());
    send_item(mk_item(1999, 0, 1'b1, base + 32'd11005), gap_len());
    // floor at and above the limit cuts heating, load holds
    send_item(mk_item(500, 2500, 1'b1, base + 32'd11006), gap_len());
    send_item(mk_item(500, 32767, 1'b1, base + 32'd11007), gap_len());
    // off-peak curve and tariff changes
    send_item(mk_item(500, 0, 1'b0, base + 32'd11008), gap_len());
    send_item(mk_item(-500, 0, 1'b0, 32'hFFFF_FFFF), gap_len());
    send_item(mk_item(1000, 0, 1'b1, 32'h0), gap_len());
    drain();

    // zero period: restart at every step, relay stays off
    reg_val[REG_CYCLE_PERIOD] = 0;
    set_config();
    send_item(mk_item(-1000, 0, 1'b1, 32'h1234_5678), gap_len());
    send_item(mk_item(500, 0, 1'b1, 32'h1234_5679), gap_len());
    drain();

    // 3600 s period, peak disabled, off-peak off below full, register extremes
    reg_val[REG_CYCLE_PERIOD] = 3600;
    reg_val[REG_PEAK_OFF]     = 32767;
    reg_val[REG_PEAK_FULL]    = -32768;
    reg_val[REG_OFFPEAK_OFF]  = -100;
    reg_val[REG_OFFPEAK_FULL] = 100;
    reg_val[REG_FLOOR_LIMIT]  = 32767;
    reg_val[REG_PEAK_EN]      = 0;
    set_config();
    send_item(mk_item(0, 0, 1'b1, 32'h8000_0000), gap_len());
    send_item(mk_item(-100, 0, 1'b0, 32'h8000_0001), gap_len());
    send_item(mk_item(-101, 32766, 1'b0, 32'h8000_0002), gap_len());
    send_item(mk_item(32767, 0, 1'b0, 32'h8036_EE80), gap_len());
    drain();

    // random phases, each with its own settings
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick_config();
      no_gap = ($urandom_range(0, 3) == 0);
      set_config();
      cur_now   = $urandom;
      phase_len = $urandom_range(15, 60);
      repeat (phase_len) begin
        random_item(item);
        send_item(item, gap_len());
        sent++;
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("heating_curve_relay_pwm regression: pass");
    else
      $display("heating_curve_relay_pwm regression: fail");
    $finish;
  end

endmodule

### filelist.f
src/hcrp_pkg.sv
src/hcrp_div.sv
src/heating_curve_relay_pwm.sv
dv/hcrp_checker.sv
dv/tb_heating_curve_relay_pwm.sv
